[rtl/assert_macros.svh]
// assertion macros shared by the frame decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define HTFD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every edge, reset included
`define HTFD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

[rtl/htfd_pkg.sv]
// shared types and constants of the humidity and temperature frame decoder
package htfd_pkg;

   localparam int BYTE_W = 8;
   localparam int RAW_W = 16;
   localparam int TEMP_W = 15;
   localparam int HUM_W = 14;

   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
   localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [RAW_W-1:0] temp_raw;
      logic [RAW_W-1:0] hum_raw;
      logic crc_good;
   } frame_type;

endpackage

[rtl/htfd_if.sv]
// valid/ready channels for bytes in and measurement results out
interface htfd_req_if;
   logic valid;
   logic ready;
   logic [htfd_pkg::BYTE_W-1:0] rx_byte;
   logic frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface htfd_rsp_if;
   logic valid;
   logic ready;
   logic signed [htfd_pkg::TEMP_W-1:0] temperature_centi;
   logic [htfd_pkg::HUM_W-1:0] humidity_centi;
   logic status;

   modport source (output valid, output temperature_centi, output humidity_centi,
                   output status, input ready);
   modport sink (input valid, input temperature_centi, input humidity_centi,
                 input status, output ready);
endinterface

[rtl/humidity_temp_frame_decoder.sv]
// top level of the humidity and temperature frame decoder
//
//   channel   dir  beat                                         handshake
//   req_if    in   rx_byte, frame_start                         valid/ready
//   rsp_if    out  temperature_centi, humidity_centi, status    valid/ready
//
// one byte beat accepted per cycle while ready is high; each result passes through
// queue entry, multiply stage, divide-and-offset stage into the output register
// req_if.ready drops only while the two-entry frame queue is full
// synchronous reset puts the framer at the first byte and empties queue and pipeline
module humidity_temp_frame_decoder (
   input  logic       clock,
   input  logic       reset,
   htfd_req_if.sink   req_if,
   htfd_rsp_if.source rsp_if
);
   import htfd_pkg::*;

   logic push_valid, push_ready;
   frame_type push_data;
   logic pop_valid, pop_ready;
   frame_type pop_data;

   htfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   htfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   htfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_if    (rsp_if)
   );

endmodule

[rtl/htfd_front.sv]
// byte framer: tracks frame position, checks both word crcs, pushes finished frames
`include "assert_macros.svh"

module htfd_front (
   input  logic                clock,
   input  logic                reset,
   htfd_req_if.sink            req_if,
   output logic                push_valid,
   input  logic                push_ready,
   output htfd_pkg::frame_type push_data
);
   import htfd_pkg::*;

   typedef enum logic [5:0] {
      POS_T_MSB = 6'b000001,
      POS_T_LSB = 6'b000010,
      POS_T_CRC = 6'b000100,
      POS_H_MSB = 6'b001000,
      POS_H_LSB = 6'b010000,
      POS_H_CRC = 6'b100000
   } pos_type;

   function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[BYTE_W-1] ? ({c[BYTE_W-2:0], 1'b0} ^ CRC_POLY) : {c[BYTE_W-2:0], 1'b0};
      end
      return c;
   endfunction

   pos_type pos_ff, pos_in, pos_cur;
   logic [BYTE_W-1:0] crc_ff, crc_in;
   logic [RAW_W-1:0] stage_ff, stage_in;
   logic [RAW_W-1:0] temp_raw_ff, temp_raw_in;
   logic temp_good_ff, temp_good_in;
   logic accept;
   logic [BYTE_W-1:0] b;

   assign req_if.ready = push_ready;
   assign accept = req_if.valid && req_if.ready;
   assign b = req_if.rx_byte;

   always_comb begin
      pos_cur = req_if.frame_start ? POS_T_MSB : pos_ff;
      pos_in = pos_ff;
      crc_in = crc_ff;
      stage_in = stage_ff;
      temp_raw_in = temp_raw_ff;
      temp_good_in = temp_good_ff;
      push_valid = 1'b0;
      push_data.temp_raw = temp_raw_ff;
      push_data.hum_raw = stage_ff;
      push_data.crc_good = temp_good_ff && (crc_ff == b);
      if (accept) begin
         unique case (pos_cur)
            POS_T_LSB: begin
               crc_in = crc8_feed(crc_ff, b);
               stage_in = {stage_ff[RAW_W-1:BYTE_W], b};
               pos_in = POS_T_CRC;
            end
            POS_T_CRC: begin
               temp_raw_in = stage_ff;
               temp_good_in = (crc_ff == b);
               crc_in = CRC_INIT;
               pos_in = POS_H_MSB;
            end
            POS_H_MSB: begin
               crc_in = crc8_feed(CRC_INIT, b);
               stage_in = {b, {BYTE_W{1'b0}}};
               pos_in = POS_H_LSB;
            end
            POS_H_LSB: begin
               crc_in = crc8_feed(crc_ff, b);
               stage_in = {stage_ff[RAW_W-1:BYTE_W], b};
               pos_in = POS_H_CRC;
            end
            POS_H_CRC: begin
               push_valid = 1'b1;
               crc_in = CRC_INIT;
               pos_in = POS_T_MSB;
            end
            default: begin
               crc_in = crc8_feed(CRC_INIT, b);
               stage_in = {b, {BYTE_W{1'b0}}};
               pos_in = POS_T_LSB;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_T_MSB;
         crc_ff <= CRC_INIT;
         stage_ff <= '0;
         temp_raw_ff <= '0;
         temp_good_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         stage_ff <= stage_in;
         temp_raw_ff <= temp_raw_in;
         temp_good_ff <= temp_good_in;
      end
   end

   `HTFD_ASSERT(a_wrap_after_sixth, (accept && pos_cur == POS_H_CRC) |=> (pos_ff == POS_T_MSB), "position did not wrap after sixth beat")
   `HTFD_ASSERT(a_push_only_ready, push_valid |-> push_ready, "frame pushed into a full queue")

endmodule

[rtl/htfd_queue.sv]
// short queue of finished frames between the framer and the converter
`include "assert_macros.svh"

module htfd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  htfd_pkg::frame_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output htfd_pkg::frame_type pop_data
);
   import htfd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_type entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data = entries_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `HTFD_ASSERT(a_count_bound, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
   `HTFD_ASSERT(a_count_push, (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1), "queue count missed a push")

endmodule

[rtl/htfd_back.sv]
// converter: scales raw words to hundredths, two stages, registered result
`include "assert_macros.svh"

module htfd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  htfd_pkg::frame_type pop_data,
   htfd_rsp_if.source          rsp_if
);
   import htfd_pkg::*;

   localparam int PROD_W = 31;
   localparam int QUO_W = PROD_W - RAW_W;
   localparam logic [RAW_W-1:0] RAW_FULL = 16'hFFFF;
   localparam logic [QUO_W-1:0] T_SPAN = 15'd17500;
   localparam logic [QUO_W-1:0] H_SPAN = 15'd10000;
   localparam logic [QUO_W:0] T_OFFSET = 16'd4500;

   // floor(x / 65535): quotient estimate x >> 16, remainder below twice the divisor
   function automatic logic [QUO_W-1:0] div_full(input logic [PROD_W-1:0] x);
      logic [QUO_W-1:0] q0;
      logic [RAW_W:0] r0;
      q0 = x[PROD_W-1:RAW_W];
      r0 = {1'b0, x[RAW_W-1:0]} + {{(RAW_W + 1 - QUO_W){1'b0}}, q0};
      return (r0 >= {1'b0, RAW_FULL}) ? q0 + 1'b1 : q0;
   endfunction

   logic s1_valid_ff, s1_valid_in;
   logic [PROD_W-1:0] s1_tprod_ff;
   logic [PROD_W-1:0] s1_hprod_ff;
   logic s1_good_ff;
   logic s1_ready, s2_ready;
   logic out_valid_ff, out_valid_in;
   logic signed [TEMP_W-1:0] temp_ff;
   logic [HUM_W-1:0] hum_ff;
   logic status_ff;
   logic [QUO_W-1:0] t_quo, h_quo;
   logic [QUO_W:0] t_off;

   assign s2_ready = !out_valid_ff || rsp_if.ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign pop_ready = s1_ready;

   assign t_quo = div_full(s1_tprod_ff);
   assign h_quo = div_full(s1_hprod_ff);
   assign t_off = {1'b0, t_quo} - T_OFFSET;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (s1_ready) begin
         s1_valid_in = pop_valid;
      end
      if (s2_ready) begin
         out_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && pop_valid) begin
         s1_tprod_ff <= PROD_W'(pop_data.temp_raw) * PROD_W'(T_SPAN);
         s1_hprod_ff <= PROD_W'(pop_data.hum_raw) * PROD_W'(H_SPAN);
         s1_good_ff <= pop_data.crc_good;
      end
      if (s2_ready && s1_valid_ff) begin
         temp_ff <= s1_good_ff ? $signed(t_off[TEMP_W-1:0]) : '0;
         hum_ff <= s1_good_ff ? h_quo[HUM_W-1:0] : '0;
         status_ff <= !s1_good_ff;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.temperature_centi = temp_ff;
   assign rsp_if.humidity_centi = hum_ff;
   assign rsp_if.status = status_ff;

   `HTFD_ASSERT(a_error_zero, (out_valid_ff && status_ff) |-> (temp_ff == '0 && hum_ff == '0), "error result carries nonzero values")
   `HTFD_ASSERT_ALWAYS(a_reset_empty, reset |=> (!out_valid_ff && !s1_valid_ff), "pipeline not empty after reset")

endmodule
